// ----- src/ghdc_pkg.sv -----
// Shared types, constants and calendar helper functions for the date converter.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package ghdc_pkg;

  localparam int YEAR_W = 17;       // signed year inside the datapath
  localparam int CNT_W  = 26;       // signed absolute day count
  localparam int DIV_W  = 34;       // signed dividend of the shared divider
  localparam int MAG_W  = DIV_W - 1;
  localparam int DVS_W  = 18;       // divisor width
  localparam int OFF_W  = 9;        // day offset within a year
  localparam int RCP_W  = 31;       // reciprocal width
  localparam int RCP_SH = MAG_W;    // reciprocals are scaled by 2**RCP_SH

  localparam int HIJ_DAY0 = 227015; // day count of the first day of Hijri year 1

  localparam logic MODE_G2H = 1'b0;

  typedef logic signed [YEAR_W-1:0] year_t;
  typedef logic signed [CNT_W-1:0]  cnt_t;
  typedef logic signed [DIV_W-1:0]  dvd_t;
  typedef logic [DVS_W-1:0]         dvs_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic [RCP_W-1:0]         rcp_t;

  localparam dvs_t DVS_CENTURY  = dvs_t'(100);
  localparam dvs_t DVS_HIJ_CYC  = dvs_t'(30);
  localparam dvs_t DVS_HIJ_EST  = dvs_t'(10631);
  localparam dvs_t DVS_GREG_EST = dvs_t'(146097);
  localparam dvs_t DVS_WEEK     = dvs_t'(7);

  // floor(2**RCP_SH / divisor): the quotient estimate is low by at most one.
  localparam rcp_t RCP_CENTURY  = rcp_t'(85899345);
  localparam rcp_t RCP_HIJ_CYC  = rcp_t'(286331153);
  localparam rcp_t RCP_HIJ_EST  = rcp_t'(808008);
  localparam rcp_t RCP_GREG_EST = rcp_t'(58796);
  localparam rcp_t RCP_WEEK     = rcp_t'(1227133513);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_SRC,
    OP_SUM_SRC,
    OP_DIV_EST,
    OP_SET_EST,
    OP_DIV_LO,
    OP_SUM_LO,
    OP_DEC_YEAR,
    OP_DIV_HI,
    OP_SUM_HI,
    OP_INC_YEAR,
    OP_MON_INIT,
    OP_MON_STEP,
    OP_DIV_WK,
    OP_OUT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRC_GO,
    S_SRC_WAIT,
    S_SRC_SUM,
    S_EST_GO,
    S_EST_WAIT,
    S_EST_SET,
    S_LO_GO,
    S_LO_WAIT,
    S_LO_SUM,
    S_LO_CHK,
    S_HI_GO,
    S_HI_WAIT,
    S_HI_SUM,
    S_HI_CHK,
    S_MON_INIT,
    S_MON,
    S_WK_GO,
    S_WK_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic lo_gt_a;
    logic hi_le_a;
    logic mon_more;
  } status_t;

  // Days in Gregorian months before month m; months past 12 count 31 days.
  function automatic off_t greg_cum(input logic [3:0] m, input logic leap);
    off_t base;
    case (m)
      4'd0:    base = off_t'(0);
      4'd1:    base = off_t'(0);
      4'd2:    base = off_t'(31);
      4'd3:    base = off_t'(59);
      4'd4:    base = off_t'(90);
      4'd5:    base = off_t'(120);
      4'd6:    base = off_t'(151);
      4'd7:    base = off_t'(181);
      4'd8:    base = off_t'(212);
      4'd9:    base = off_t'(243);
      4'd10:   base = off_t'(273);
      4'd11:   base = off_t'(304);
      4'd12:   base = off_t'(334);
      4'd13:   base = off_t'(365);
      4'd14:   base = off_t'(396);
      4'd15:   base = off_t'(427);
      default: base = off_t'(0);
    endcase
    return base + ((leap && m >= 4'd3) ? off_t'(1) : off_t'(0));
  endfunction

  // Days in Hijri months before month m; month 0 gives minus 29.
  function automatic logic signed [9:0] hij_cum(input logic [3:0] m);
    logic signed [9:0] mm;
    mm = signed'({6'b0, m});
    return mm * 10'sd29 - 10'sd29 + signed'({7'b0, m[3:1]});
  endfunction

  function automatic logic [4:0] greg_mdays(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [4:0] hij_mdays(input logic [3:0] m, input logic leap);
    return (m[0] || (m == 4'd12 && leap)) ? 5'd30 : 5'd29;
  endfunction

endpackage

`default_nettype wire

// ----- src/ghdc_div.sv -----
// Shared constant divider: signed dividend by one of the package divisors, in three
// steps (reciprocal multiply, back-multiply and subtract, one correction).
// Gives the floor quotient, floor remainder and the remainder of the magnitude.
`default_nettype none

module ghdc_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  ghdc_pkg::dvd_t  dvd_i,
  input  ghdc_pkg::dvs_t  dvs_i,
  output logic            busy_o,
  output ghdc_pkg::dvd_t  quo_o,
  output ghdc_pkg::dvs_t  rem_o,
  output ghdc_pkg::dvs_t  raw_o
);

  localparam int MAG_W  = ghdc_pkg::MAG_W;
  localparam int DVS_W  = ghdc_pkg::DVS_W;
  localparam int RCP_W  = ghdc_pkg::RCP_W;
  localparam int PRD_W  = MAG_W + RCP_W;
  localparam int EXT_W  = MAG_W + 1;
  localparam logic [1:0] LAST = 2'd2;

  logic                busy_q, busy_d;
  logic [1:0]          cnt_q, cnt_d;
  logic [MAG_W-1:0]    mag_q, mag_d;
  ghdc_pkg::rcp_t      rcp_q, rcp_d;
  logic [MAG_W-1:0]    quo_q, quo_d;
  logic [DVS_W:0]      part_q, part_d;
  ghdc_pkg::dvs_t      rem_q, rem_d;
  ghdc_pkg::dvs_t      dvs_q, dvs_d;
  logic                neg_q, neg_d;

  ghdc_pkg::dvd_t      mag;
  ghdc_pkg::rcp_t      rcp;
  logic [PRD_W-1:0]    prod;
  logic [EXT_W-1:0]    back;
  logic [EXT_W-1:0]    diff;
  logic                fix;
  ghdc_pkg::dvd_t      quo_u;

  always_comb begin
    case (dvs_i)
      ghdc_pkg::DVS_CENTURY:  rcp = ghdc_pkg::RCP_CENTURY;
      ghdc_pkg::DVS_HIJ_CYC:  rcp = ghdc_pkg::RCP_HIJ_CYC;
      ghdc_pkg::DVS_HIJ_EST:  rcp = ghdc_pkg::RCP_HIJ_EST;
      ghdc_pkg::DVS_GREG_EST: rcp = ghdc_pkg::RCP_GREG_EST;
      ghdc_pkg::DVS_WEEK:     rcp = ghdc_pkg::RCP_WEEK;
      default:                rcp = '0;
    endcase
  end

  always_comb begin
    mag  = dvd_i[ghdc_pkg::DIV_W-1] ? -dvd_i : dvd_i;
    prod = PRD_W'(mag_q) * PRD_W'(rcp_q);
    back = EXT_W'(quo_q) * EXT_W'(dvs_q);
    diff = {1'b0, mag_q} - back;

    busy_d = busy_q;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rcp_d  = rcp_q;
    quo_d  = quo_q;
    part_d = part_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = mag[MAG_W-1:0];
      rcp_d  = rcp;
      dvs_d  = dvs_i;
      neg_d  = dvd_i[ghdc_pkg::DIV_W-1];
    end else if (busy_q) begin
      cnt_d = cnt_q + 2'd1;
      case (cnt_q)
        2'd0: quo_d = MAG_W'(prod >> ghdc_pkg::RCP_SH);
        // The estimate is at most one low, so the rest is below twice the divisor.
        2'd1: part_d = diff[DVS_W:0];
        default: begin
          if (part_q >= {1'b0, dvs_q}) begin
            quo_d = quo_q + MAG_W'(1);
            rem_d = ghdc_pkg::dvs_t'(part_q - {1'b0, dvs_q});
          end else begin
            rem_d = part_q[DVS_W-1:0];
          end
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rcp_q  <= rcp_d;
    quo_q  <= quo_d;
    part_q <= part_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
  end

  // Turn the magnitude result into floor quotient and remainder.
  always_comb begin
    fix    = neg_q && (rem_q != '0);
    quo_u  = {1'b0, quo_q};
    quo_o  = neg_q ? -(quo_u + (fix ? ghdc_pkg::dvd_t'(1) : ghdc_pkg::dvd_t'(0))) : quo_u;
    rem_o  = fix ? dvs_q - rem_q : rem_q;
    raw_o  = rem_q;
    busy_o = busy_q;
  end

  a_part_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == LAST) |-> (part_q < {dvs_q, 1'b0}))
    else $error("quotient estimate more than one low");

  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == LAST) |=> (rem_q < dvs_q))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- src/ghdc_datapath.sv -----
// Datapath: input and working registers, day count arithmetic, month search and
// output registers. Holds the shared divider. Depends on ghdc_pkg and ghdc_div.
`default_nettype none

module ghdc_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              mode_i,
  input  logic [4:0]        in_day_i,
  input  logic [3:0]        in_month_i,
  input  logic signed [14:0] in_year_i,
  input  ghdc_pkg::cmd_t    cmd_i,
  output ghdc_pkg::status_t status_o,
  output logic [4:0]        out_day_o,
  output logic [3:0]        out_month_o,
  output logic [13:0]       out_year_o,
  output logic              before_epoch_o,
  output logic [2:0]        weekday_o,
  output logic [4:0]        source_month_days_o,
  output logic [4:0]        target_month_days_o,
  output logic [4:0]        next_month_days_o
);

  typedef ghdc_pkg::cnt_t  cnt_t;
  typedef ghdc_pkg::dvd_t  dvd_t;
  typedef ghdc_pkg::year_t year_t;
  typedef ghdc_pkg::off_t  off_t;

  // Day count of Gregorian year x+1 start, less one, given q = floor(x / 100).
  function automatic cnt_t greg_base(input cnt_t x, input cnt_t q);
    return cnt_t'(x * 365) + (x >>> 2) - q + (q >>> 2);
  endfunction

  logic        mode_q;
  logic [4:0]  day_q;
  logic [3:0]  mon_q;
  year_t       yr_q;
  year_t       ty_q, ty_d;
  cnt_t        a_q, a_d;
  cnt_t        slo_q, slo_d;
  cnt_t        shi_q, shi_d;
  logic [4:0]  src_len_q, src_len_d;
  off_t        off_q, off_d;
  logic        leapt_q, leapt_d;
  logic [3:0]  tm_q, tm_d;

  logic        div_start;
  dvd_t        div_dvd;
  ghdc_pkg::dvs_t div_dvs;
  logic        div_busy;
  dvd_t        div_quo;
  ghdc_pkg::dvs_t div_rem;
  ghdc_pkg::dvs_t div_raw;

  dvd_t        yr_x, ty_x, a_x;
  cnt_t        yr_c, ty_c, q_c, day_c;
  logic        leap_g, leap_h;
  cnt_t        src_g, src_h;
  cnt_t        lo_cnt, hi_cnt;
  off_t        cum_next, cum_cur;
  logic [3:0]  next_m;
  year_t       fold;
  off_t        td;

  ghdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .raw_o   (div_raw)
  );

  // Divider operands.
  always_comb begin
    yr_x      = dvd_t'(yr_q);
    ty_x      = dvd_t'(ty_q);
    a_x       = dvd_t'(a_q);
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = ghdc_pkg::DVS_WEEK;
    case (cmd_i.op)
      ghdc_pkg::OP_DIV_SRC: begin
        div_start = 1'b1;
        if (mode_q == ghdc_pkg::MODE_G2H) begin
          div_dvd = yr_x - dvd_t'(1);
          div_dvs = ghdc_pkg::DVS_CENTURY;
        end else begin
          div_dvd = dvd_t'(yr_x * 11) + dvd_t'(3);
          div_dvs = ghdc_pkg::DVS_HIJ_CYC;
        end
      end
      ghdc_pkg::OP_DIV_EST: begin
        div_start = 1'b1;
        if (mode_q == ghdc_pkg::MODE_G2H) begin
          div_dvd = dvd_t'((a_x - dvd_t'(ghdc_pkg::HIJ_DAY0)) * 30);
          div_dvs = ghdc_pkg::DVS_HIJ_EST;
        end else begin
          div_dvd = dvd_t'(a_x * 400);
          div_dvs = ghdc_pkg::DVS_GREG_EST;
        end
      end
      ghdc_pkg::OP_DIV_LO: begin
        div_start = 1'b1;
        if (mode_q == ghdc_pkg::MODE_G2H) begin
          div_dvd = dvd_t'(ty_x * 11) + dvd_t'(3);
          div_dvs = ghdc_pkg::DVS_HIJ_CYC;
        end else begin
          div_dvd = ty_x - dvd_t'(1);
          div_dvs = ghdc_pkg::DVS_CENTURY;
        end
      end
      ghdc_pkg::OP_DIV_HI: begin
        div_start = 1'b1;
        if (mode_q == ghdc_pkg::MODE_G2H) begin
          div_dvd = dvd_t'(ty_x * 11) + dvd_t'(14);
          div_dvs = ghdc_pkg::DVS_HIJ_CYC;
        end else begin
          div_dvd = ty_x;
          div_dvs = ghdc_pkg::DVS_CENTURY;
        end
      end
      ghdc_pkg::OP_DIV_WK: begin
        div_start = 1'b1;
        div_dvd   = a_x;
        div_dvs   = ghdc_pkg::DVS_WEEK;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Day counts built from the last division.
  always_comb begin
    yr_c  = cnt_t'(yr_q);
    ty_c  = cnt_t'(ty_q);
    q_c   = cnt_t'(div_quo);
    day_c = cnt_t'(signed'({1'b0, day_q}));

    // Source year y, divided as y-1 by 100 or as 11y+3 by 30.
    leap_g = ((yr_c[1:0] == 2'b00) && (div_rem != ghdc_pkg::dvs_t'(99)))
          || ((q_c[1:0] == 2'b11) && (div_rem == ghdc_pkg::dvs_t'(99)));
    leap_h = div_rem >= ghdc_pkg::dvs_t'(19);
    src_g  = day_c + cnt_t'(signed'({1'b0, ghdc_pkg::greg_cum(mon_q, leap_g)}))
           + greg_base(yr_c - cnt_t'(1), q_c);
    src_h  = day_c + cnt_t'(ghdc_pkg::hij_cum(mon_q)) + cnt_t'((yr_c - cnt_t'(1)) * 354)
           + q_c + cnt_t'(ghdc_pkg::HIJ_DAY0 - 1);

    if (mode_q == ghdc_pkg::MODE_G2H) begin
      lo_cnt = cnt_t'((ty_c - cnt_t'(1)) * 354) + q_c + cnt_t'(ghdc_pkg::HIJ_DAY0);
      hi_cnt = cnt_t'(ty_c * 354) + q_c + cnt_t'(ghdc_pkg::HIJ_DAY0);
    end else begin
      lo_cnt = greg_base(ty_c - cnt_t'(1), q_c) + cnt_t'(1);
      hi_cnt = greg_base(ty_c, q_c) + cnt_t'(1);
    end
  end

  // Month search helpers for the target calendar.
  always_comb begin
    next_m = (tm_q == 4'd12) ? 4'd1 : tm_q + 4'd1;
    if (mode_q == ghdc_pkg::MODE_G2H) begin
      cum_next = off_t'(ghdc_pkg::hij_cum(tm_q + 4'd1));
      cum_cur  = off_t'(ghdc_pkg::hij_cum(tm_q));
    end else begin
      cum_next = ghdc_pkg::greg_cum(tm_q + 4'd1, leapt_q);
      cum_cur  = ghdc_pkg::greg_cum(tm_q, leapt_q);
    end
    td   = off_q - cum_cur + off_t'(1);
    fold = (ty_q <= year_t'(0)) ? year_t'(1) - ty_q : ty_q;
  end

  always_comb begin
    status_o.div_busy = div_busy;
    status_o.lo_gt_a  = slo_q > a_q;
    status_o.hi_le_a  = shi_q <= a_q;
    status_o.mon_more = (tm_q < 4'd12) && (off_q >= cum_next);
  end

  always_comb begin
    ty_d      = ty_q;
    a_d       = a_q;
    slo_d     = slo_q;
    shi_d     = shi_q;
    src_len_d = src_len_q;
    off_d     = off_q;
    leapt_d   = leapt_q;
    tm_d      = tm_q;
    case (cmd_i.op)
      ghdc_pkg::OP_SUM_SRC: begin
        if (mode_q == ghdc_pkg::MODE_G2H) begin
          a_d       = src_g;
          src_len_d = ghdc_pkg::greg_mdays(mon_q, leap_g);
        end else begin
          a_d       = src_h;
          src_len_d = ghdc_pkg::hij_mdays(mon_q, leap_h);
        end
      end
      ghdc_pkg::OP_SET_EST:  ty_d  = year_t'(div_quo) + year_t'(1);
      ghdc_pkg::OP_SUM_LO:   slo_d = lo_cnt;
      ghdc_pkg::OP_DEC_YEAR: ty_d  = ty_q - year_t'(1);
      ghdc_pkg::OP_SUM_HI:   shi_d = hi_cnt;
      ghdc_pkg::OP_INC_YEAR: begin
        ty_d  = ty_q + year_t'(1);
        slo_d = shi_q;
      end
      ghdc_pkg::OP_MON_INIT: begin
        off_d   = off_t'(a_q - slo_q);
        leapt_d = (shi_q - slo_q) ==
                  ((mode_q == ghdc_pkg::MODE_G2H) ? cnt_t'(355) : cnt_t'(366));
        tm_d    = 4'd1;
      end
      ghdc_pkg::OP_MON_STEP: tm_d = tm_q + 4'd1;
      default: begin
        tm_d = tm_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == ghdc_pkg::OP_LOAD) begin
      mode_q <= mode_i;
      day_q  <= in_day_i;
      mon_q  <= in_month_i;
      // No year zero on input: shift negative years up by one.
      yr_q   <= year_t'(in_year_i) + (in_year_i[14] ? year_t'(1) : year_t'(0));
    end
    ty_q      <= ty_d;
    a_q       <= a_d;
    slo_q     <= slo_d;
    shi_q     <= shi_d;
    src_len_q <= src_len_d;
    off_q     <= off_d;
    leapt_q   <= leapt_d;
    tm_q      <= tm_d;
    if (cmd_i.op == ghdc_pkg::OP_OUT) begin
      out_day_o           <= td[4:0];
      out_month_o         <= tm_q;
      out_year_o          <= fold[13:0];
      before_epoch_o      <= (ty_q <= year_t'(0));
      weekday_o           <= div_raw[2:0];
      source_month_days_o <= src_len_q;
      if (mode_q == ghdc_pkg::MODE_G2H) begin
        target_month_days_o <= ghdc_pkg::hij_mdays(tm_q, leapt_q);
        next_month_days_o   <= ghdc_pkg::hij_mdays(next_m, leapt_q);
      end else begin
        target_month_days_o <= ghdc_pkg::greg_mdays(tm_q, leapt_q);
        next_month_days_o   <= ghdc_pkg::greg_mdays(next_m, leapt_q);
      end
    end
  end

  a_month_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == ghdc_pkg::OP_MON_STEP) |-> (tm_q < 4'd12))
    else $error("month search ran past the twelfth month");

endmodule

`default_nettype wire

// ----- src/ghdc_ctrl.sv -----
// Controller state machine: sequences the divisions, year search and month search,
// and owns the input and output handshakes. Depends on ghdc_pkg.
`default_nettype none

module ghdc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  ghdc_pkg::status_t status_i,
  output ghdc_pkg::cmd_t    cmd_o
);

  ghdc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ghdc_pkg::S_IDLE:     if (in_valid_i) state_d = ghdc_pkg::S_SRC_GO;
      ghdc_pkg::S_SRC_GO:   state_d = ghdc_pkg::S_SRC_WAIT;
      ghdc_pkg::S_SRC_WAIT: if (!status_i.div_busy) state_d = ghdc_pkg::S_SRC_SUM;
      ghdc_pkg::S_SRC_SUM:  state_d = ghdc_pkg::S_EST_GO;
      ghdc_pkg::S_EST_GO:   state_d = ghdc_pkg::S_EST_WAIT;
      ghdc_pkg::S_EST_WAIT: if (!status_i.div_busy) state_d = ghdc_pkg::S_EST_SET;
      ghdc_pkg::S_EST_SET:  state_d = ghdc_pkg::S_LO_GO;
      ghdc_pkg::S_LO_GO:    state_d = ghdc_pkg::S_LO_WAIT;
      ghdc_pkg::S_LO_WAIT:  if (!status_i.div_busy) state_d = ghdc_pkg::S_LO_SUM;
      ghdc_pkg::S_LO_SUM:   state_d = ghdc_pkg::S_LO_CHK;
      ghdc_pkg::S_LO_CHK:   state_d = status_i.lo_gt_a ? ghdc_pkg::S_LO_GO : ghdc_pkg::S_HI_GO;
      ghdc_pkg::S_HI_GO:    state_d = ghdc_pkg::S_HI_WAIT;
      ghdc_pkg::S_HI_WAIT:  if (!status_i.div_busy) state_d = ghdc_pkg::S_HI_SUM;
      ghdc_pkg::S_HI_SUM:   state_d = ghdc_pkg::S_HI_CHK;
      ghdc_pkg::S_HI_CHK:   state_d = status_i.hi_le_a ? ghdc_pkg::S_HI_GO : ghdc_pkg::S_MON_INIT;
      ghdc_pkg::S_MON_INIT: state_d = ghdc_pkg::S_MON;
      ghdc_pkg::S_MON:      if (!status_i.mon_more) state_d = ghdc_pkg::S_WK_GO;
      ghdc_pkg::S_WK_GO:    state_d = ghdc_pkg::S_WK_WAIT;
      ghdc_pkg::S_WK_WAIT:  if (!status_i.div_busy) state_d = ghdc_pkg::S_FINISH;
      ghdc_pkg::S_FINISH:   if (out_free) state_d = ghdc_pkg::S_IDLE;
      default:              state_d = ghdc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = ghdc_pkg::OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ghdc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = ghdc_pkg::OP_LOAD;
      end
      ghdc_pkg::S_SRC_GO:   cmd_o.op = ghdc_pkg::OP_DIV_SRC;
      ghdc_pkg::S_SRC_SUM:  cmd_o.op = ghdc_pkg::OP_SUM_SRC;
      ghdc_pkg::S_EST_GO:   cmd_o.op = ghdc_pkg::OP_DIV_EST;
      ghdc_pkg::S_EST_SET:  cmd_o.op = ghdc_pkg::OP_SET_EST;
      ghdc_pkg::S_LO_GO:    cmd_o.op = ghdc_pkg::OP_DIV_LO;
      ghdc_pkg::S_LO_SUM:   cmd_o.op = ghdc_pkg::OP_SUM_LO;
      ghdc_pkg::S_LO_CHK:   if (status_i.lo_gt_a) cmd_o.op = ghdc_pkg::OP_DEC_YEAR;
      ghdc_pkg::S_HI_GO:    cmd_o.op = ghdc_pkg::OP_DIV_HI;
      ghdc_pkg::S_HI_SUM:   cmd_o.op = ghdc_pkg::OP_SUM_HI;
      ghdc_pkg::S_HI_CHK:   if (status_i.hi_le_a) cmd_o.op = ghdc_pkg::OP_INC_YEAR;
      ghdc_pkg::S_MON_INIT: cmd_o.op = ghdc_pkg::OP_MON_INIT;
      ghdc_pkg::S_MON:      if (status_i.mon_more) cmd_o.op = ghdc_pkg::OP_MON_STEP;
      ghdc_pkg::S_WK_GO:    cmd_o.op = ghdc_pkg::OP_DIV_WK;
      ghdc_pkg::S_FINISH:   if (out_free) cmd_o.op = ghdc_pkg::OP_OUT;
      default:              cmd_o.op = ghdc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == ghdc_pkg::OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghdc_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_div_idle_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == ghdc_pkg::OP_DIV_SRC || cmd_o.op == ghdc_pkg::OP_DIV_EST ||
     cmd_o.op == ghdc_pkg::OP_DIV_LO || cmd_o.op == ghdc_pkg::OP_DIV_HI ||
     cmd_o.op == ghdc_pkg::OP_DIV_WK) |-> !status_i.div_busy)
    else $error("divider started while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ghdc_pkg::S_SRC_GO))
    else $error("accepted word did not start a conversion");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ghdc_pkg::S_FINISH && out_valid_q && !out_ready_i)
      |=> (state_q == ghdc_pkg::S_FINISH && out_valid_q))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- src/gregorian_hijri_date_converter.sv -----
// Gregorian <-> tabular Islamic date converter, top level.
// Depends on ghdc_pkg, ghdc_ctrl and ghdc_datapath.
//
// Input channel: in_valid_i/in_ready_o with mode_i (0 Gregorian to Hijri,
// 1 Hijri to Gregorian), in_day_i, in_month_i and signed in_year_i.
// Output channel: out_valid_o/out_ready_i with the converted day, month,
// folded year, before-epoch flag, weekday and three month lengths.
// One word is converted at a time. Each word runs a division for the source
// count, one for the year estimate, one per year probe (at least one low and
// one high) and one for the weekday on a shared three-step constant divider,
// plus up to eleven month steps, before the result is registered. The next
// word is accepted once the previous result is in the output register, even
// if it is still waiting.
// Reset clears the controller to idle with no result pending. When the
// receiver stalls, the result is held unchanged and a finished conversion
// waits until the output register frees.
`default_nettype none

module gregorian_hijri_date_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [4:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic signed [14:0] in_year_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic [13:0]        out_year_o,
  output logic               before_epoch_o,
  output logic [2:0]         weekday_o,
  output logic [4:0]         source_month_days_o,
  output logic [4:0]         target_month_days_o,
  output logic [4:0]         next_month_days_o
);

  ghdc_pkg::cmd_t    cmd;
  ghdc_pkg::status_t status;

  ghdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ghdc_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .mode_i              (mode_i),
    .in_day_i            (in_day_i),
    .in_month_i          (in_month_i),
    .in_year_i           (in_year_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .out_day_o           (out_day_o),
    .out_month_o         (out_month_o),
    .out_year_o          (out_year_o),
    .before_epoch_o      (before_epoch_o),
    .weekday_o           (weekday_o),
    .source_month_days_o (source_month_days_o),
    .target_month_days_o (target_month_days_o),
    .next_month_days_o   (next_month_days_o)
  );

endmodule

`default_nettype wire
